/* rtl/nfa_pkg.sv */
// Shared types and constants of the NFA regex matcher.
package nfa_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_BEGIN  = 2'd1,
        ACT_CHAR   = 2'd2,
        ACT_FINISH = 2'd3
    } t_action;

    localparam logic [1:0] KIND_LABEL = 2'd0;
    localparam logic [1:0] KIND_SPLIT = 2'd1;
    localparam logic [1:0] KIND_MATCH = 2'd2;

    localparam int unsigned ENTRY_W  = 34;
    localparam int unsigned STACK_D  = 256;
    localparam int unsigned MARKS_D  = 256;
    localparam logic [2:0]  REG_START = 3'd0;
    localparam logic [2:0]  REG_COUNT = 3'd4;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_LIST_RD = 8'b0000_0010,
        S_LIST_WT = 8'b0000_0100,
        S_TBL_WT  = 8'b0000_1000,
        S_CL_CHK  = 8'b0001_0000,
        S_CL_TBL  = 8'b0010_0000,
        S_POP_WT  = 8'b0100_0000,
        S_FIN_OUT = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic wr_table;
        logic begin_init;
        logic char_init;
        logic fin_init;
        logic list_rd;
        logic tbl_rd_list;
        logic j_inc;
        logic cl_load;
        logic cl_mark;
        logic push;
        logic append;
        logic pop_rd;
        logic pop_ld;
        logic phase_flip;
        logic hit_set;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic j_lt_count;
        logic lbl_hit;
        logic is_match;
        logic skip;
        logic is_split;
        logic sp_zero;
        logic out_busy;
    } t_status;

endpackage

/* rtl/nfa_regex_matcher_core.sv */
// Top level of the NFA regex matcher: stream ports, register port, core.
//
// Usage: load the NFA table with write items (tuser = 0), then send a
// begin item (1), one character item (2) per byte, and a finish item (3).
// Only a finish item yields a result item on the master side, carrying
// the matched flag in tdata bit 0. start_state and state_count are set
// over the register port (byte addresses 0 and 4) while the block is idle.
//
// Sequencing: a write item leaves the block ready for the next item. A
// begin item walks the closure of the start entry. A character item
// reads each entry of the active list and walks the closure from every
// entry whose label takes the character; a finish item scans the active
// list for a match entry. The single sequencer walks the list memory and
// the table memory, each with a registered read, one access per step.
//
// Reset clears the lists, the phase, the visit marks and the output;
// the table must be written before use. The result sits in an output
// register: while the receiver stalls, the block keeps taking items and
// only a following finish item waits for the register to drain.
module nfa_regex_matcher_core #(
    parameter int unsigned MAX_STATES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: entry_index[7:0], entry_kind[9:8], entry_next_first[17:10],
    // entry_next_second[25:18], entry_low[33:26], entry_high[41:34],
    // char_code[49:42], zero fill up to bit 55
    input  logic [55:0] s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: matched[0], zero fill up to bit 7
    output logic [7:0]  m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nfa_pkg::*;

    logic [7:0] r_start;
    logic [8:0] r_count;
    logic       accept, idle, matched;
    t_cmd       cmd;
    t_status    status;

    // Register port: zero wait states, address bit 2 selects the register.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 8'd0;
            r_count <= 9'd256;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_COUNT[2]) begin
                r_count <= pwdata[8:0];
            end else begin
                r_start <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_COUNT[2]) begin
            prdata = {23'd0, r_count};
        end else begin
            prdata = {24'd0, r_start};
        end
    end

    // Take an item only while the sequencer is at rest.
    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    nfa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (s_axis_tuser),
        .i_status (status),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    nfa_dp #(.MAX_STATES(MAX_STATES)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_start             (r_start),
        .i_count             (r_count),
        .i_entry_index       (s_axis_tdata[7:0]),
        .i_entry_kind        (s_axis_tdata[9:8]),
        .i_entry_next_first  (s_axis_tdata[17:10]),
        .i_entry_next_second (s_axis_tdata[25:18]),
        .i_entry_low         (s_axis_tdata[33:26]),
        .i_entry_high        (s_axis_tdata[41:34]),
        .i_char_code         (s_axis_tdata[49:42]),
        .i_out_ready         (m_axis_tready),
        .o_status            (status),
        .o_out_valid         (m_axis_tvalid),
        .o_matched           (matched)
    );

    assign m_axis_tdata = {7'd0, matched};
endmodule

/* rtl/nfa_ram.sv */
// Generic simple dual-port RAM with registered read.
module nfa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/nfa_ctrl.sv */
// Sequencer of the NFA matcher: list walk, closure and finish scan.
module nfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_action,
    input  nfa_pkg::t_status i_status,
    output nfa_pkg::t_cmd    o_cmd,
    output logic             o_idle
);
    import nfa_pkg::*;

    t_state  r_state, n_state;
    t_action r_mode, n_mode;

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= ACT_WRITE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        t_state ret;
        ret     = (r_mode == ACT_CHAR) ? S_LIST_RD : S_IDLE;
        o_cmd   = '0;
        n_state = r_state;
        n_mode  = r_mode;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_mode = t_action'(i_action);
                    case (t_action'(i_action))
                        ACT_WRITE:  o_cmd.wr_table = 1'b1;
                        ACT_BEGIN: begin
                            o_cmd.begin_init = 1'b1;
                            n_state = S_CL_CHK;
                        end
                        ACT_CHAR: begin
                            o_cmd.char_init = 1'b1;
                            n_state = S_LIST_RD;
                        end
                        ACT_FINISH: begin
                            o_cmd.fin_init = 1'b1;
                            n_state = S_LIST_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LIST_RD: begin
                if (i_status.j_lt_count) begin
                    o_cmd.list_rd = 1'b1;
                    n_state = S_LIST_WT;
                end else if (r_mode == ACT_CHAR) begin
                    o_cmd.phase_flip = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FIN_OUT;
                end
            end
            S_LIST_WT: begin
                o_cmd.tbl_rd_list = 1'b1;
                n_state = S_TBL_WT;
            end
            S_TBL_WT: begin
                o_cmd.j_inc = 1'b1;
                n_state = S_LIST_RD;
                if (r_mode == ACT_CHAR) begin
                    if (i_status.lbl_hit) begin
                        o_cmd.cl_load = 1'b1;
                        n_state = S_CL_CHK;
                    end
                end else if (i_status.is_match) begin
                    o_cmd.hit_set = 1'b1;
                end
            end
            S_CL_CHK: begin
                if (!i_status.skip) begin
                    o_cmd.cl_mark = 1'b1;
                    n_state = S_CL_TBL;
                end else if (i_status.sp_zero) begin
                    n_state = ret;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                    n_state = S_POP_WT;
                end
            end
            S_CL_TBL: begin
                if (i_status.is_split) begin
                    o_cmd.push = 1'b1;
                    n_state = S_CL_CHK;
                end else begin
                    o_cmd.append = 1'b1;
                    if (i_status.sp_zero) begin
                        n_state = ret;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state = S_POP_WT;
                    end
                end
            end
            S_POP_WT: begin
                o_cmd.pop_ld = 1'b1;
                n_state = S_CL_CHK;
            end
            S_FIN_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* rtl/nfa_dp.sv */
// Datapath of the NFA matcher: table, active lists, closure stack, marks.
module nfa_dp #(
    parameter int unsigned MAX_STATES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nfa_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_start,
    input  logic [8:0]       i_count,
    input  logic [7:0]       i_entry_index,
    input  logic [1:0]       i_entry_kind,
    input  logic [7:0]       i_entry_next_first,
    input  logic [7:0]       i_entry_next_second,
    input  logic [7:0]       i_entry_low,
    input  logic [7:0]       i_entry_high,
    input  logic [7:0]       i_char_code,
    input  logic             i_out_ready,
    output nfa_pkg::t_status o_status,
    output logic             o_out_valid,
    output logic             o_matched
);
    import nfa_pkg::*;

    localparam int unsigned LA = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int unsigned CW = $clog2(MAX_STATES + 1);
    localparam int unsigned LD = 2 << LA;
    localparam int unsigned SA = $clog2(STACK_D);

    logic [7:0]          r_s;
    logic [SA:0]         r_sp;
    logic [CW-1:0]       r_j, r_cnt0, r_cnt1;
    logic                r_phase, r_which, r_ent_ok, r_hit;
    logic [7:0]          r_char;
    logic [MARKS_D-1:0]  r_marks;
    logic                r_out_valid, r_out_matched;

    logic [ENTRY_W-1:0]  tbl_rdata;
    logic [7:0]          list_rdata, stk_rdata;
    logic [LA-1:0]       tbl_raddr;
    logic [1:0]          kind;
    logic [7:0]          nxt1, nxt2, lo, hi;
    logic [CW-1:0]       cnt_cur, cnt_w;
    logic [SA:0]         sp_m1;
    logic [31:0]         lim;
    logic                can_append;

    assign kind = tbl_rdata[33:32];
    assign nxt1 = tbl_rdata[31:24];
    assign nxt2 = tbl_rdata[23:16];
    assign lo   = tbl_rdata[15:8];
    assign hi   = tbl_rdata[7:0];

    assign cnt_cur    = r_phase ? r_cnt1 : r_cnt0;
    assign cnt_w      = r_which ? r_cnt1 : r_cnt0;
    assign sp_m1      = r_sp - 1'b1;
    assign lim        = (32'(i_count) > MAX_STATES) ? MAX_STATES : 32'(i_count);
    assign can_append = i_cmd.append && (32'(cnt_w) < MAX_STATES);
    assign tbl_raddr  = i_cmd.tbl_rd_list ? LA'(list_rdata) : LA'(r_s);

    nfa_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << LA)) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_table && (32'(i_entry_index) < MAX_STATES)),
        .i_waddr (LA'(i_entry_index)),
        .i_wdata ({i_entry_kind, i_entry_next_first, i_entry_next_second,
                   i_entry_low, i_entry_high}),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    nfa_ram #(.WIDTH(8), .DEPTH(LD)) u_lists (
        .i_clk   (i_clk),
        .i_we    (can_append),
        .i_waddr ({r_which, cnt_w[LA-1:0]}),
        .i_wdata (r_s),
        .i_raddr ({r_phase, r_j[LA-1:0]}),
        .o_rdata (list_rdata)
    );

    nfa_ram #(.WIDTH(8), .DEPTH(STACK_D)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_sp[SA-1:0]),
        .i_wdata (nxt2),
        .i_raddr (sp_m1[SA-1:0]),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        o_status.j_lt_count = (r_j < cnt_cur);
        o_status.lbl_hit    = r_ent_ok && (kind == KIND_LABEL) && !r_char[7]
                              && (lo <= r_char) && (r_char <= hi);
        o_status.is_match   = r_ent_ok && (kind == KIND_MATCH);
        o_status.skip       = (r_s == 8'd0) || (32'(r_s) >= lim) || r_marks[r_s];
        o_status.is_split   = (kind == KIND_SPLIT);
        o_status.sp_zero    = (r_sp == '0);
        o_status.out_busy   = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_out_matched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt0      <= '0;
            r_cnt1      <= '0;
            r_phase     <= 1'b0;
            r_which     <= 1'b0;
            r_sp        <= '0;
            r_j         <= '0;
            r_marks     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.begin_init) begin
                r_cnt0  <= '0;
                r_cnt1  <= '0;
                r_phase <= 1'b0;
                r_which <= 1'b0;
                r_marks <= '0;
                r_sp    <= '0;
            end
            if (i_cmd.char_init) begin
                r_which <= ~r_phase;
                r_marks <= '0;
                r_sp    <= '0;
                r_j     <= '0;
                if (r_phase) begin
                    r_cnt0 <= '0;
                end else begin
                    r_cnt1 <= '0;
                end
            end
            if (i_cmd.fin_init) begin
                r_j   <= '0;
                r_hit <= 1'b0;
            end
            if (i_cmd.j_inc) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.cl_mark) begin
                r_marks[r_s] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_sp <= r_sp + 1'b1;
            end
            if (i_cmd.pop_rd) begin
                r_sp <= sp_m1;
            end
            if (can_append) begin
                if (r_which) begin
                    r_cnt1 <= r_cnt1 + 1'b1;
                end else begin
                    r_cnt0 <= r_cnt0 + 1'b1;
                end
            end
            if (i_cmd.phase_flip) begin
                r_phase <= ~r_phase;
            end
            if (i_cmd.hit_set) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.char_init) begin
            r_char <= i_char_code;
        end
        if (i_cmd.tbl_rd_list) begin
            r_ent_ok <= (32'(list_rdata) < MAX_STATES);
        end
        if (i_cmd.begin_init) begin
            r_s <= i_start;
        end else if (i_cmd.cl_load) begin
            r_s <= nxt1;
        end else if (i_cmd.push) begin
            r_s <= nxt1;
        end else if (i_cmd.pop_ld) begin
            r_s <= stk_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_matched <= r_hit;
        end
    end
endmodule

/* rtl/nfa_checker.sv */
// Port-level assertions for the NFA matcher, bound to the top level.
module nfa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import nfa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item present after reset");

    a_busy_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_WRITE)
        |=> !s_axis_tready)
        else $error("ready right after a begin, character or finish item");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("nonzero fill bits in result item");
endmodule

bind nfa_regex_matcher_core nfa_checker u_nfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* dv/nfa_regex_matcher_core_tb.sv */
// Testbench of the NFA regex matcher: table loads, random patterns and strings, checked on finish.
`timescale 1ns / 100ps

module nfa_regex_matcher_core_tb;
    import nfa_pkg::*;

    localparam int unsigned TABLE_D = 256;
    localparam int unsigned CYCLE_LIMIT = 20000000;

    // Expected matched flags, oldest first, compared against the result items.
    class match_scoreboard;
        bit   exp_q[$];
        int   fail_count;

        function void note_finish(bit hit);
            exp_q.push_back(hit);
        endfunction

        function bit check_result(bit got, output string msg);
            bit want;
            if (exp_q.size() == 0) begin
                msg = $sformatf("unexpected result matched=%0d", got);
                return 0;
            end
            want = exp_q.pop_front();
            if (want !== got) begin
                msg = $sformatf("matched got %0d want %0d", got, want);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nfa_regex_matcher_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Predictor state: own copy of the table, lists and registers.
    // ---------------------------------------------------------------
    logic [1:0] nfa_kind   [TABLE_D];
    logic [7:0] nfa_next1  [TABLE_D];
    logic [7:0] nfa_next2  [TABLE_D];
    logic [7:0] nfa_low    [TABLE_D];
    logic [7:0] nfa_high   [TABLE_D];
    int         live_list  [2][$];
    bit         list_sel;
    bit         seen       [TABLE_D];
    logic [7:0] cfg_start;
    logic [8:0] cfg_count;

    match_scoreboard board;
    int          fail_total;
    longint      cycle_count = 0;

    // Print one mismatch line and count it.
    task automatic report(input string msg);
        fail_total++;
        $display("%0t: ERROR %s", $realtime, msg);
    endtask

    // Depth-first epsilon closure into list dst; splits pass through.
    function automatic void walk_closure(input bit dst, input int first);
        int stack[$];
        int s;
        int lim;
        lim = (cfg_count > TABLE_D) ? TABLE_D : cfg_count;
        stack.push_back(first);
        while (stack.size() > 0) begin
            s = stack.pop_back();
            if (s == 0 || s >= lim || seen[s]) continue;
            seen[s] = 1'b1;
            if (nfa_kind[s] == KIND_SPLIT) begin
                stack.push_back(nfa_next2[s]);
                stack.push_back(nfa_next1[s]);
            end else if (live_list[dst].size() < TABLE_D) begin
                live_list[dst].push_back(s);
            end
        end
    endfunction

    // Advance the predictor by one accepted item; note a finish result.
    function automatic void predict_item(input t_action act, input logic [55:0] d);
        int   idx;
        bit   nxt;
        bit   hit;
        logic [7:0] c;
        case (act)
            ACT_WRITE: begin
                idx = d[7:0];
                nfa_kind[idx]  = d[9:8];
                nfa_next1[idx] = d[17:10];
                nfa_next2[idx] = d[25:18];
                nfa_low[idx]   = d[33:26];
                nfa_high[idx]  = d[41:34];
            end
            ACT_BEGIN: begin
                live_list[0].delete();
                live_list[1].delete();
                list_sel = 1'b0;
                foreach (seen[k]) seen[k] = 1'b0;
                walk_closure(1'b0, cfg_start);
            end
            ACT_CHAR: begin
                c = d[49:42];
                nxt = ~list_sel;
                foreach (seen[k]) seen[k] = 1'b0;
                live_list[nxt].delete();
                foreach (live_list[list_sel][j]) begin
                    idx = live_list[list_sel][j];
                    // unsigned byte compare: high bytes never match
                    if (nfa_kind[idx] == KIND_LABEL && c < 8'h80 &&
                        nfa_low[idx] <= c && c <= nfa_high[idx])
                        walk_closure(nxt, nfa_next1[idx]);
                end
                list_sel = nxt;
            end
            default: begin
                hit = 1'b0;
                foreach (live_list[list_sel][j])
                    if (nfa_kind[live_list[list_sel][j]] == KIND_MATCH) hit = 1'b1;
                board.note_finish(hit);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Random gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 93) n = $urandom_range(1, 4);
        else n = $urandom_range(10, 60);
        return n;
    endfunction

    // Offer one item and hold it until accepted; valid drops only for a gap.
    task automatic send_item(input t_action act, input logic [55:0] d);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(act, d);
    endtask

    task automatic put_entry(input int idx, input logic [1:0] kind, input int n1,
                             input int n2, input int lo, input int hi);
        logic [55:0] d;
        d = '0;
        d[7:0] = 8'(idx); d[9:8] = kind; d[17:10] = 8'(n1); d[25:18] = 8'(n2);
        d[33:26] = 8'(lo); d[41:34] = 8'(hi);
        // the character field is a don't-care here; exercise its bits anyway
        d[49:42] = 8'($urandom);
        send_item(ACT_WRITE, d);
    endtask

    task automatic put_ctrl(input t_action act, input int c);
        logic [55:0] d;
        d = '0;
        d[41:0] = 42'({$urandom, $urandom});
        d[49:42] = 8'(c);
        send_item(act, d);
    endtask

    // Stop offering, wait until every expected result is back and the core is idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.exp_q.size() > 0) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == REG_START) cfg_start = val[7:0];
        else cfg_count = val[8:0];
    endtask

    task automatic set_regs(input int start, input int count);
        drain();
        apb_write(REG_START, start);
        apb_write(REG_COUNT, count);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Fill the whole table so no unwritten entry is ever read.
    task automatic fill_table();
        for (int i = 0; i < TABLE_D; i++)
            put_entry(i, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
    endtask

    // String run: begin, characters biased to the printable half, random extra finishes, finish.
    task automatic run_string(input int len);
        put_ctrl(ACT_BEGIN, $urandom);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) put_ctrl(ACT_CHAR, $urandom);
            else put_ctrl(ACT_CHAR, $urandom_range(8'h20, 8'h7f));
            if ($urandom_range(0, 7) == 0) put_ctrl(ACT_FINISH, 0);
        end
        put_ctrl(ACT_FINISH, 0);
    endtask

    // Small random NFA over entries 1..n: labels with narrow ranges, splits, matches.
    task automatic load_pattern(input int n);
        int k;
        for (int i = 1; i <= n; i++) begin
            k = $urandom_range(0, 9);
            if (k < 6)
                put_entry(i, KIND_LABEL, $urandom_range(0, n), 0,
                          $urandom_range(8'h20, 8'h60), $urandom_range(8'h40, 8'h7f));
            else if (k < 8)
                put_entry(i, KIND_SPLIT, $urandom_range(0, n), $urandom_range(0, n), 0, 0);
            else
                put_entry(i, KIND_MATCH, 0, 0, 0, 0);
        end
    endtask

    // Accept results; the receiver stalls at random.
    initial begin
        string msg;
        int    n;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                if (!board.check_result(m_axis_tdata[0], msg)) report(msg);
        end
    end

    // Hard stop on a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nfa_regex_matcher_core: mismatch");
            $finish;
        end
    end

    initial begin
        board = new();
        fail_total = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_WRITE;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_start = 8'd0;
        cfg_count = 9'd256;
        list_sel = 1'b0;
        foreach (seen[k]) seen[k] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Finish and character before any begin: empty lists answer 0.
        put_ctrl(ACT_FINISH, 0);
        put_ctrl(ACT_CHAR, 8'h41);
        put_ctrl(ACT_FINISH, 0);

        // Directed: a(zero byte up to b)* over entries 1..4, inert entry 5 and empty range.
        put_entry(0, KIND_MATCH, 0, 0, 0, 0);           // null entry, never entered
        put_entry(1, KIND_LABEL, 2, 0, 8'h61, 8'h61);   // 'a'
        put_entry(2, KIND_SPLIT, 3, 4, 0, 0);
        put_entry(3, KIND_LABEL, 2, 0, 8'h00, 8'h62);   // zero byte up to 'b'
        put_entry(4, KIND_MATCH, 0, 0, 0, 0);
        put_entry(5, 2'd3, 1, 1, 8'h00, 8'hff);         // kind three is inert
        put_entry(6, KIND_LABEL, 4, 0, 8'h70, 8'h10);   // empty range
        put_entry(255, KIND_LABEL, 4, 0, 8'hff, 8'hff);
        set_regs(1, 256);
        put_ctrl(ACT_BEGIN, 0);
        put_ctrl(ACT_CHAR, 8'h61);
        put_ctrl(ACT_FINISH, 0);
        put_ctrl(ACT_CHAR, 8'h00);
        put_ctrl(ACT_CHAR, 8'hE1);                      // high byte kills the run
        put_ctrl(ACT_FINISH, 0);
        set_regs(6, 7);
        put_ctrl(ACT_BEGIN, 0);
        put_ctrl(ACT_CHAR, 8'h50);
        put_ctrl(ACT_FINISH, 0);
        set_regs(0, 256);                               // null start
        put_ctrl(ACT_BEGIN, 0);
        put_ctrl(ACT_FINISH, 0);
        set_regs(255, 256);
        put_ctrl(ACT_BEGIN, 0);
        put_ctrl(ACT_CHAR, 8'h7f);
        put_ctrl(ACT_FINISH, 0);

        // Random phases: whole table random, then small patterns on top.
        fill_table();
        for (int ph = 0; ph < 8; ph++) begin
            int n;
            n = $urandom_range(3, 12);
            load_pattern(n);
            case (ph % 4)
                0: set_regs(1, 256);
                1: set_regs($urandom_range(1, n), 1);    // count of one leaves no usable entry
                2: set_regs(1, $urandom_range(2, n + 1)); // may cut the pattern
                default: set_regs($urandom_range(0, 255), $urandom_range(1, 256));
            endcase
            for (int r = 0; r < 12; r++) begin
                run_string($urandom_range(0, 8));
                if ($urandom_range(0, 5) == 0)         // rewrite an entry between runs
                    put_entry($urandom_range(1, n), 2'($urandom_range(0, 3)),
                              $urandom_range(0, n), $urandom_range(0, n),
                              $urandom, $urandom);
            end
            if (ph == 3) drain();                       // sender holds off till empty
        end
        // Dense random table with wide reach.
        set_regs($urandom_range(1, 255), 256);
        for (int r = 0; r < 100; r++) run_string($urandom_range(0, 5));

        drain();
        repeat (200) @(posedge i_clk);
        fail_total += board.exp_q.size();
        if (fail_total == 0)
            $display("nfa_regex_matcher_core: match");
        else
            $display("nfa_regex_matcher_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/nfa_pkg.sv
rtl/nfa_ram.sv
rtl/nfa_ctrl.sv
rtl/nfa_dp.sv
rtl/nfa_regex_matcher_core.sv
rtl/nfa_checker.sv
dv/nfa_regex_matcher_core_tb.sv
